@@ rtl/time_code_pulse_frame_decoder_top_defines.svh @@
// Assertion macros shared by the checker of the time-code pulse frame decoder.
// Include with the bare file name; assumes signals clock and reset in scope.
`ifndef TIME_CODE_PULSE_FRAME_DECODER_TOP_DEFINES_SVH
`define TIME_CODE_PULSE_FRAME_DECODER_TOP_DEFINES_SVH

// checked only outside reset
`define TCPFD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define TCPFD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/tcpfd_pkg.sv @@
// Package of the time-code pulse frame decoder: symbol codes, register indexes,
// result layout and the BCD time decode. No dependencies.
package tcpfd_pkg;

   localparam int HISTORY_DEPTH_DEF = 10;
   localparam int FRAME_BITS_DEF    = 60;

   localparam int THR_W   = 11;
   localparam int PULSE_W = 16;
   localparam int CSR_A_W = 2;
   localparam int REQ_W   = 16;
   localparam int RSP_W   = 48;

   localparam logic [THR_W-1:0] ERROR_BELOW_RST = 11'd100;
   localparam logic [THR_W-1:0] ONE_FROM_RST    = 11'd400;
   localparam logic [THR_W-1:0] MARKER_FROM_RST = 11'd700;
   localparam logic [THR_W-1:0] ERROR_FROM_RST  = 11'd900;

   localparam logic [5:0] FRAME_MARKERS = 6'd6;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_ERROR_BELOW = 2'd0,
      CSR_ONE_FROM    = 2'd1,
      CSR_MARKER_FROM = 2'd2,
      CSR_ERROR_FROM  = 2'd3
   } csr_addr_type;

   typedef enum logic [2:0] {
      SYM_ZERO = 3'd0,
      SYM_ONE  = 3'd1,
      SYM_MARK = 3'd2,
      SYM_ERR  = 3'd3,
      SYM_END  = 3'd4
   } sym_type;

   typedef struct packed {
      logic latched;
      logic dropped;
      logic have_time;
   } frame_status_type;

   // packed MSB first: minute in the lowest bits
   typedef struct packed {
      logic [1:0] dst_flags;
      logic       leap_year;
      logic [7:0] year_two_digit;
      logic [8:0] day_of_year;
      logic [5:0] hour;
      logic [6:0] minute;
   } time_fields_type;

   // packed MSB first: pad on top, symbol in the lowest bits
   typedef struct packed {
      logic [4:0]      pad;
      logic [3:0]      recent_errors;
      time_fields_type tf;
      logic            have_time;
      logic            frame_dropped;
      logic            frame_latched;
      logic [2:0]      symbol;
   } rsp_fields_type;

   function automatic time_fields_type decode_time(input logic [63:0] f);
      time_fields_type t;
      t.minute         = 7'(7'(f[63:61]) * 7'd10) + 7'(f[59:56]);
      t.hour           = 6'(6'(f[52:51]) * 6'd10) + 6'(f[49:46]);
      t.day_of_year    = 9'(9'(f[42:41]) * 9'd100) + 9'(9'(f[39:36]) * 9'd10)
                         + 9'(f[34:31]);
      t.year_two_digit = 8'(8'(f[19:16]) * 8'd10) + 8'(f[14:11]);
      t.leap_year      = f[9];
      t.dst_flags      = f[7:6];
      return t;
   endfunction

endpackage

@@ rtl/time_code_pulse_frame_decoder_top.sv @@
// Time-code pulse frame decoder: top level with request and result registers.
// Depends on tcpfd_pkg, tcpfd_classify and tcpfd_frame.
//
// Usage:
//   req_* carries one low-pulse width in ms per transaction (tdata[15:0]).
//   rsp_* returns exactly one result per request: the pulse class, frame
//   latched/dropped flags, have_time, the BCD-decoded time fields of the
//   last good frame and the count of dropped frames among recent outcomes.
//   csr_* writes the four 11-bit thresholds (index 0..3) while idle.
// Timing:
//   A request waits in the request register while classification, frame
//   update and time decode run combinationally into the result register;
//   rsp_tvalid rises once the result register is loaded. Throughput is
//   one transaction per cycle while rsp_tready stays high.
// Reset: synchronous; thresholds return to 100/400/700/900 ms, frame state
//   clears, the outcome history reads all dropped, both registers empty.
// Stall: while rsp_tready is low the result holds; one more request is
//   taken into the request register, then req_tready drops.
module time_code_pulse_frame_decoder_top #(
   parameter int HISTORY_DEPTH = tcpfd_pkg::HISTORY_DEPTH_DEF,
   parameter int FRAME_BITS    = tcpfd_pkg::FRAME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tcpfd_pkg::REQ_W-1:0]   req_tdata,  // [15:0] pulse_width_ms
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [2:0] symbol, [3] frame_latched, [4] frame_dropped, [5] have_time,
   // [12:6] minute, [18:13] hour, [27:19] day_of_year, [35:28] year_two_digit,
   // [36] leap_year, [38:37] dst_flags, [42:39] recent_errors, [47:43] zero
   output logic [tcpfd_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                          csr_wen,
   input  logic [tcpfd_pkg::CSR_A_W-1:0] csr_addr,
   input  logic [tcpfd_pkg::THR_W-1:0]   csr_wdata
);
   import tcpfd_pkg::*;

   logic                 in_valid_ff, out_valid_ff;
   logic [PULSE_W-1:0]   pulse_ff;
   rsp_fields_type       out_ff, out_in;
   logic                 advance;
   sym_type              sym_class, sym_final;
   frame_status_type     status;
   logic [63:0]          latched_next;
   logic [3:0]           recent_errors;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) pulse_ff <= req_tdata[PULSE_W-1:0];
      if (advance) out_ff <= out_in;
   end

   tcpfd_classify u_classify (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .pulse_width_ms (pulse_ff),
      .symbol         (sym_class)
   );

   tcpfd_frame #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .FRAME_BITS    (FRAME_BITS)
   ) u_frame (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .sym_class     (sym_class),
      .sym_final     (sym_final),
      .status        (status),
      .latched_next  (latched_next),
      .recent_errors (recent_errors)
   );

   always_comb begin
      out_in.pad           = '0;
      out_in.recent_errors = recent_errors;
      out_in.tf            = decode_time(latched_next);
      out_in.have_time     = status.have_time;
      out_in.frame_dropped = status.dropped;
      out_in.frame_latched = status.latched;
      out_in.symbol        = sym_final;
   end

endmodule

@@ rtl/tcpfd_classify.sv @@
// Threshold registers and pulse-width classifier of the time-code decoder.
// Depends on tcpfd_pkg.
module tcpfd_classify (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [tcpfd_pkg::CSR_A_W-1:0] csr_addr,
   input  logic [tcpfd_pkg::THR_W-1:0]   csr_wdata,
   input  logic [tcpfd_pkg::PULSE_W-1:0] pulse_width_ms,
   output tcpfd_pkg::sym_type            symbol
);
   import tcpfd_pkg::*;

   logic [THR_W-1:0] error_below_ff, one_from_ff, marker_from_ff, error_from_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_below_ff <= ERROR_BELOW_RST;
         one_from_ff    <= ONE_FROM_RST;
         marker_from_ff <= MARKER_FROM_RST;
         error_from_ff  <= ERROR_FROM_RST;
      end else if (csr_wen) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_ERROR_BELOW: error_below_ff <= csr_wdata;
            CSR_ONE_FROM:    one_from_ff    <= csr_wdata;
            CSR_MARKER_FROM: marker_from_ff <= csr_wdata;
            CSR_ERROR_FROM:  error_from_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (pulse_width_ms < PULSE_W'(error_below_ff)) symbol = SYM_ERR;
      else if (pulse_width_ms < PULSE_W'(one_from_ff))        symbol = SYM_ZERO;
      else if (pulse_width_ms < PULSE_W'(marker_from_ff))     symbol = SYM_ONE;
      else if (pulse_width_ms < PULSE_W'(error_from_ff))      symbol = SYM_MARK;
      else                                                    symbol = SYM_ERR;
   end

endmodule

@@ rtl/tcpfd_frame.sv @@
// Frame assembly, frame check, latched frame and outcome history.
// Depends on tcpfd_pkg.
module tcpfd_frame #(
   parameter int HISTORY_DEPTH = tcpfd_pkg::HISTORY_DEPTH_DEF,
   parameter int FRAME_BITS    = tcpfd_pkg::FRAME_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  tcpfd_pkg::sym_type           sym_class,
   output tcpfd_pkg::sym_type           sym_final,
   output tcpfd_pkg::frame_status_type  status,
   output logic [63:0]                  latched_next,
   output logic [3:0]                   recent_errors
);
   import tcpfd_pkg::*;

   localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int SUM_W = ($clog2(HISTORY_DEPTH + 1) < 4) ? 4 : $clog2(HISTORY_DEPTH + 1);
   localparam logic [6:0]       FRAME_POS = 7'(FRAME_BITS);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(HISTORY_DEPTH - 1);

   logic [63:0]              shift_ff, shift_in, latched_ff, latched_in;
   logic [6:0]               bit_index_ff, bit_index_in;
   logic [5:0]               marker_ff, marker_in, bad_ff, bad_in;
   logic                     prev_mark_ff, prev_mark_in;
   logic                     time_valid_ff, time_valid_in;
   logic [HISTORY_DEPTH-1:0] ring_ff, ring_in;
   logic [PTR_W-1:0]         ptr_ff, ptr_in;
   logic                     log_en, log_drop, latch_now, drop_now;
   logic [5:0]               pos;
   logic [SUM_W-1:0]         err_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff      <= '0;
         latched_ff    <= '0;
         bit_index_ff  <= 7'd1;
         marker_ff     <= '0;
         bad_ff        <= '0;
         prev_mark_ff  <= 1'b0;
         time_valid_ff <= 1'b0;
         ring_ff       <= '1;
         ptr_ff        <= '0;
      end else begin
         shift_ff      <= shift_in;
         latched_ff    <= latched_in;
         bit_index_ff  <= bit_index_in;
         marker_ff     <= marker_in;
         bad_ff        <= bad_in;
         prev_mark_ff  <= prev_mark_in;
         time_valid_ff <= time_valid_in;
         ring_ff       <= ring_in;
         ptr_ff        <= ptr_in;
      end
   end

   always_comb begin
      shift_in      = shift_ff;
      latched_in    = latched_ff;
      bit_index_in  = bit_index_ff;
      marker_in     = marker_ff;
      bad_in        = bad_ff;
      prev_mark_in  = prev_mark_ff;
      time_valid_in = time_valid_ff;
      sym_final     = sym_class;
      log_en        = 1'b0;
      log_drop      = 1'b0;
      latch_now     = 1'b0;
      drop_now      = 1'b0;
      pos           = 6'(7'd64 - bit_index_ff);
      if (advance) begin
         if (sym_class == SYM_MARK && prev_mark_ff) begin
            sym_final = SYM_END;
            log_en    = 1'b1;
            if (marker_ff == FRAME_MARKERS && bit_index_ff == FRAME_POS && bad_ff == '0) begin
               latched_in    = shift_ff;
               time_valid_in = 1'b1;
               latch_now     = 1'b1;
            end else begin
               log_drop = 1'b1;
               drop_now = 1'b1;
            end
         end else begin
            if (bit_index_ff >= 7'd1 && bit_index_ff <= 7'd63)
               shift_in = shift_ff | (64'(sym_class == SYM_ONE) << pos);
            if (bit_index_ff < 7'd127)
               bit_index_in = bit_index_ff + 7'd1;
            if (sym_class == SYM_MARK) begin
               if (marker_ff < 6'd63) marker_in = marker_ff + 6'd1;
               prev_mark_in = 1'b1;
            end else begin
               if (sym_class == SYM_ERR && bad_ff < 6'd63) bad_in = bad_ff + 6'd1;
               prev_mark_in = 1'b0;
            end
            if (bit_index_in > FRAME_POS) begin
               log_en   = 1'b1;
               log_drop = 1'b1;
               drop_now = 1'b1;
            end
         end
         if (log_en) begin
            shift_in     = '0;
            bit_index_in = 7'd1;
            marker_in    = '0;
            bad_in       = '0;
            prev_mark_in = 1'b0;
         end
      end
   end

   always_comb begin
      ring_in = ring_ff;
      ptr_in  = ptr_ff;
      if (log_en) begin
         ring_in[ptr_ff] = log_drop;
         ptr_in = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + PTR_W'(1);
      end
   end

   always_comb begin
      err_sum = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++)
         err_sum = err_sum + SUM_W'(ring_in[i]);
   end

   assign recent_errors    = (err_sum > SUM_W'(15)) ? 4'd15 : err_sum[3:0];
   assign latched_next     = latched_in;
   assign status.latched   = latch_now;
   assign status.dropped   = drop_now;
   assign status.have_time = time_valid_in;

endmodule

@@ rtl/tcpfd_checker.sv @@
// Port-level checker of the time-code pulse frame decoder, bound to the top.
// Depends on tcpfd_pkg and time_code_pulse_frame_decoder_top_defines.svh.
`include "time_code_pulse_frame_decoder_top_defines.svh"

module tcpfd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [tcpfd_pkg::RSP_W-1:0] rsp_tdata
);
   import tcpfd_pkg::*;

   rsp_fields_type r;
   assign r = rsp_tdata;

   `TCPFD_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result valid after reset")
   `TCPFD_ASSERT(a_latch_xor_drop, rsp_tvalid |-> !(r.frame_latched && r.frame_dropped),
      "frame both latched and dropped")
   `TCPFD_ASSERT(a_latch_is_end, (rsp_tvalid && r.frame_latched) |->
      (r.symbol == SYM_END && r.have_time), "latch without frame end or time")
   `TCPFD_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)),
      "stalled result changed")
   `TCPFD_ASSERT(a_time_kept, (rsp_tvalid && rsp_tready && r.have_time) |=>
      (!rsp_tvalid || r.have_time), "have_time fell")

endmodule

bind time_code_pulse_frame_decoder_top tcpfd_checker u_tcpfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ sim/time_code_pulse_frame_decoder_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench for time_code_pulse_frame_decoder_top: streams framed and noisy pulse widths
// and checks each result against a built-in frame decoder predictor.
// Depends on tcpfd_pkg and the decoder RTL.
module time_code_pulse_frame_decoder_top_tb;
   import tcpfd_pkg::*;

   localparam int GAP_MAX        = 11;
   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int FRAME_SLOTS    = FRAME_BITS_DEF - 1;
   localparam int HIST_MAX       = 15;

   localparam logic [PULSE_W-1:0] DIRECTED_WIDTHS [22] = '{
      16'd0, 16'hFFFF, 16'd99, 16'd100, 16'd399, 16'd400, 16'd699, 16'd700,
      16'd899, 16'd900, 16'd2047, 16'h0800, 16'h5555, 16'hAAAA, 16'd750, 16'd399,
      16'd800, 16'd850, 16'd250, 16'd550, 16'h8000, 16'd1
   };

   typedef enum int {
      FR_GOOD, FR_BAD_BIT, FR_FEW_MARKS, FR_MANY_MARKS, FR_SHORT, FR_OVERRUN, FR_NOISE
   } frame_kind_type;

   typedef struct {
      sym_type    symbol;
      logic       latched;
      logic       dropped;
      logic       have_time;
      logic [6:0] minute;
      logic [5:0] hour;
      logic [8:0] day_of_year;
      logic [7:0] year_two_digit;
      logic       leap_year;
      logic [1:0] dst_flags;
      logic [3:0] recent_errors;
   } pulse_result_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;  // [15:0] pulse_width_ms
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   // [2:0] symbol, [3] frame_latched, [4] frame_dropped, [5] have_time,
   // [12:6] minute, [18:13] hour, [27:19] day_of_year, [35:28] year_two_digit,
   // [36] leap_year, [38:37] dst_flags, [42:39] recent_errors, [47:43] zero
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_wen    = 1'b0;
   logic [CSR_A_W-1:0] csr_addr   = '0;
   logic [THR_W-1:0]   csr_wdata  = '0;

   // predictor state
   logic [THR_W-1:0] thr_ms [4] = '{ERROR_BELOW_RST, ONE_FROM_RST, MARKER_FROM_RST,
                                    ERROR_FROM_RST};
   logic [63:0] shift_reg    = '0;
   logic [63:0] good_frame   = '0;
   int          frame_pos    = 1;
   int          marks_seen   = 0;
   int          bad_bits     = 0;
   bit          after_marker = 1'b0;
   bit          time_ok      = 1'b0;
   logic [HISTORY_DEPTH_DEF-1:0] outcome_hist = '1;
   int          hist_ptr     = 0;

   logic [PULSE_W-1:0] pulse_queue [$];
   pulse_result_type   expected_results [$];

   int req_gap = 0, rsp_gap = 0, hold_left = 0, idle_cycles = 0;
   bit steady = 1'b0, hold_request = 1'b0;
   int mismatches = 0, pulses_done = 0, frames_latched = 0, frames_dropped = 0;
   int settings_used = 1;
   rsp_fields_type   seen;
   pulse_result_type want;

   time_code_pulse_frame_decoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic void clear_frame();
      shift_reg    = '0;
      frame_pos    = 1;
      marks_seen   = 0;
      bad_bits     = 0;
      after_marker = 1'b0;
   endfunction

   function automatic void record_outcome(input bit was_dropped);
      outcome_hist[hist_ptr] = was_dropped;
      hist_ptr = (hist_ptr + 1) % HISTORY_DEPTH_DEF;
      if (was_dropped) frames_dropped++;
      else frames_latched++;
   endfunction

   function automatic void predict_pulse(input logic [PULSE_W-1:0] w);
      pulse_result_type r;
      sym_type          s;
      int               errs;
      logic [63:0]      f;
      if (w < thr_ms[0]) s = SYM_ERR;
      else if (w < thr_ms[1]) s = SYM_ZERO;
      else if (w < thr_ms[2]) s = SYM_ONE;
      else if (w < thr_ms[3]) s = SYM_MARK;
      else s = SYM_ERR;
      r.latched = 1'b0;
      r.dropped = 1'b0;
      if (s == SYM_MARK && after_marker) begin
         s = SYM_END;
         if (marks_seen == 6 && frame_pos == FRAME_BITS_DEF && bad_bits == 0) begin
            good_frame = shift_reg;
            time_ok    = 1'b1;
            r.latched  = 1'b1;
            record_outcome(1'b0);
         end else begin
            r.dropped = 1'b1;
            record_outcome(1'b1);
         end
         clear_frame();
      end else begin
         if (frame_pos >= 1 && frame_pos <= 63 && s == SYM_ONE) shift_reg[64 - frame_pos] = 1'b1;
         if (frame_pos < 127) frame_pos++;
         if (s == SYM_MARK) begin
            if (marks_seen < 63) marks_seen++;
            after_marker = 1'b1;
         end else begin
            if (s == SYM_ERR && bad_bits < 63) bad_bits++;
            after_marker = 1'b0;
         end
         if (frame_pos > FRAME_BITS_DEF) begin
            r.dropped = 1'b1;
            record_outcome(1'b1);
            clear_frame();
         end
      end
      errs = $countones(outcome_hist);
      if (errs > HIST_MAX) errs = HIST_MAX;
      f = good_frame;
      r.symbol         = s;
      r.have_time      = time_ok;
      r.minute         = 7'(10 * int'(f[63:61]) + int'(f[59:56]));
      r.hour           = 6'(10 * int'(f[52:51]) + int'(f[49:46]));
      r.day_of_year    = 9'(100 * int'(f[42:41]) + 10 * int'(f[39:36]) + int'(f[34:31]));
      r.year_two_digit = 8'(10 * int'(f[19:16]) + int'(f[14:11]));
      r.leap_year      = f[9];
      r.dst_flags      = f[7:6];
      r.recent_errors  = 4'(errs);
      expected_results.push_back(r);
      pulses_done++;
   endfunction

   function automatic void check_field(input string name, input int unsigned want_v,
                                       input int unsigned got_v);
      if (want_v != got_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
         mismatches++;
      end
   endfunction

   // width inside the window of a class; assumes ordered thresholds
   function automatic logic [PULSE_W-1:0] width_for(input sym_type s);
      int lo, hi;
      case (s)
         SYM_ZERO: begin lo = int'(thr_ms[0]); hi = int'(thr_ms[1]) - 1; end
         SYM_ONE:  begin lo = int'(thr_ms[1]); hi = int'(thr_ms[2]) - 1; end
         SYM_MARK: begin lo = int'(thr_ms[2]); hi = int'(thr_ms[3]) - 1; end
         default: begin
            if (thr_ms[0] > 0 && $urandom_range(1, 0)) begin
               lo = 0;
               hi = int'(thr_ms[0]) - 1;
            end else begin
               lo = int'(thr_ms[3]);
               hi = 16'hFFFF;
            end
         end
      endcase
      case ($urandom_range(7, 0))
         0: return PULSE_W'(lo);
         1: return PULSE_W'(hi);
         default: return PULSE_W'($urandom_range(hi, lo));
      endcase
   endfunction

   // two zero-marker-marker runs always end on a frame restart
   task automatic add_resync();
      repeat (2) begin
         pulse_queue.push_back(width_for(SYM_ZERO));
         pulse_queue.push_back(width_for(SYM_MARK));
         pulse_queue.push_back(width_for(SYM_MARK));
      end
   endtask

   task automatic add_noise(input int count, input bit ordered);
      int n, w;
      for (n = 0; n < count; n++) begin
         case ($urandom_range(3, 0))
            0: pulse_queue.push_back(PULSE_W'($urandom()));
            1: pulse_queue.push_back(PULSE_W'($urandom_range(2100, 0)));
            2: begin
               w = int'(thr_ms[$urandom_range(3, 0)]) + int'($urandom_range(2, 0)) - 1;
               if (w < 0) w = 0;
               pulse_queue.push_back(PULSE_W'(w));
            end
            default: begin
               if (ordered) pulse_queue.push_back(width_for(sym_type'($urandom_range(3, 0))));
               else pulse_queue.push_back(PULSE_W'($urandom_range(2047, 0)));
            end
         endcase
      end
      if (ordered) add_resync();
   endtask

   task automatic add_frame(input frame_kind_type kind);
      sym_type slot [1:FRAME_SLOTS];
      int      mark_at [5];
      int      last, p, k;
      if (kind == FR_OVERRUN) begin
         for (p = 0; p < FRAME_BITS_DEF; p++) begin
            if ($urandom_range(15, 0) == 0) pulse_queue.push_back(width_for(SYM_ERR));
            else pulse_queue.push_back(width_for($urandom_range(1, 0) ? SYM_ONE : SYM_ZERO));
         end
      end else if (kind == FR_NOISE) begin
         add_noise($urandom_range(30, 10), 1'b1);
      end else begin
         for (p = 1; p <= FRAME_SLOTS; p++) slot[p] = $urandom_range(1, 0) ? SYM_ONE : SYM_ZERO;
         for (k = 0; k < 5; k++) begin
            mark_at[k] = 10 * k + $urandom_range(8, 3);
            slot[mark_at[k]] = SYM_MARK;
         end
         slot[FRAME_SLOTS] = SYM_MARK;
         last = FRAME_SLOTS;
         case (kind)
            FR_BAD_BIT: begin
               p = $urandom_range(FRAME_SLOTS - 1, 1);
               if (slot[p] == SYM_MARK) p++;
               slot[p] = SYM_ERR;
            end
            FR_FEW_MARKS:  slot[mark_at[$urandom_range(4, 0)]] = SYM_ZERO;
            FR_MANY_MARKS: slot[1] = SYM_MARK;
            FR_SHORT: begin
               last = $urandom_range(FRAME_SLOTS - 1, 2);
               slot[last] = SYM_MARK;
               if (slot[last - 1] == SYM_MARK) slot[last - 1] = SYM_ZERO;
            end
            default: ;
         endcase
         for (p = 1; p <= last; p++) pulse_queue.push_back(width_for(slot[p]));
         pulse_queue.push_back(width_for(SYM_MARK));
      end
   endtask

   task automatic run_frames(input int count);
      int k;
      add_resync();
      repeat (count) begin
         k = $urandom_range(11, 0);
         add_frame(k <= 5 ? FR_GOOD : frame_kind_type'(k - 5));
      end
   endtask

   task automatic write_csr(input csr_addr_type idx, input logic [THR_W-1:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      thr_ms[idx] = value;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic program_thresholds(input int e_below, input int one_from,
                                     input int mark_from, input int e_from);
      write_csr(CSR_ERROR_BELOW, THR_W'(e_below));
      write_csr(CSR_ONE_FROM, THR_W'(one_from));
      write_csr(CSR_MARKER_FROM, THR_W'(mark_from));
      write_csr(CSR_ERROR_FROM, THR_W'(e_from));
      settings_used++;
   endtask

   // sampled at the falling edge so pending transactions are settled
   task automatic wait_idle();
      do @(negedge clock);
      while (pulse_queue.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else if (req_tvalid && req_tready) begin
         predict_pulse(req_tdata[PULSE_W-1:0]);
         req_gap = steady ? 0 : $urandom_range(GAP_MAX, 0);
         if (req_gap == 0 && pulse_queue.size() > 0) begin
            req_tdata <= pulse_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end else if (!req_tvalid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (pulse_queue.size() > 0) begin
            req_tdata  <= pulse_queue.pop_front();
            req_tvalid <= 1'b1;
         end
      end
   end

   // result monitor and tready control
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (expected_results.size() == 0) begin
               $error("rsp transaction with nothing expected: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("symbol", want.symbol, seen.symbol);
               check_field("frame_latched", want.latched, seen.frame_latched);
               check_field("frame_dropped", want.dropped, seen.frame_dropped);
               check_field("have_time", want.have_time, seen.have_time);
               check_field("minute", want.minute, seen.tf.minute);
               check_field("hour", want.hour, seen.tf.hour);
               check_field("day_of_year", want.day_of_year, seen.tf.day_of_year);
               check_field("year_two_digit", want.year_two_digit, seen.tf.year_two_digit);
               check_field("leap_year", want.leap_year, seen.tf.leap_year);
               check_field("dst_flags", want.dst_flags, seen.tf.dst_flags);
               check_field("recent_errors", want.recent_errors, seen.recent_errors);
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            rsp_gap = steady ? 0 : $urandom_range(GAP_MAX, 0);
            rsp_tready <= (rsp_gap == 0);
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= (rsp_gap == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int a, b, c, d;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: window edges, extreme widths, early frame ends
      foreach (DIRECTED_WIDTHS[n]) pulse_queue.push_back(DIRECTED_WIDTHS[n]);
      wait_idle();

      // random ordered windows, with a long result stall partway through
      a = $urandom_range(400, 1);
      b = a + $urandom_range(500, 1);
      c = b + $urandom_range(500, 1);
      d = c + $urandom_range(600, 1);
      program_thresholds(a, b, c, d);
      run_frames(12);
      while (pulse_queue.size() > 400) @(posedge clock);
      hold_request = 1'b1;
      wait_idle();

      // narrowest windows, back to back
      program_thresholds(1, 2, 3, 2047);
      steady = 1'b1;
      run_frames(5);
      wait_idle();
      steady = 1'b0;

      // degenerate and out-of-order thresholds
      program_thresholds(0, 0, 0, 0);
      add_noise(50, 1'b0);
      wait_idle();
      program_thresholds(2047, 2047, 2047, 2047);
      add_noise(50, 1'b0);
      wait_idle();
      repeat (3) begin
         program_thresholds($urandom_range(2047, 0), $urandom_range(2047, 0),
                            $urandom_range(2047, 0), $urandom_range(2047, 0));
         add_noise(50, 1'b0);
         wait_idle();
      end

      program_thresholds(ERROR_BELOW_RST, ONE_FROM_RST, MARKER_FROM_RST, ERROR_FROM_RST);
      run_frames(12);
      wait_idle();

      $display("Checked %0d pulse transactions over %0d threshold settings:", pulses_done,
               settings_used);
      $display("%0d frames latched, %0d frames dropped, %0d mismatches.", frames_latched,
               frames_dropped, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ time_code_pulse_frame_decoder_top.f @@
+incdir+rtl
rtl/tcpfd_pkg.sv
rtl/tcpfd_classify.sv
rtl/tcpfd_frame.sv
rtl/time_code_pulse_frame_decoder_top.sv
rtl/tcpfd_checker.sv
sim/time_code_pulse_frame_decoder_top_tb.sv
